// ===== hw/rtl/rod_pkg.sv =====
package rod_pkg;

    localparam int KEPT_CAPACITY = 1024;
    localparam int MAX_DIMS      = 4;
    localparam int COORD_W       = 32;
    localparam int IDX_W         = 16;
    localparam int CNT_W         = $clog2(KEPT_CAPACITY + 1);
    localparam int ADDR_W        = $clog2(KEPT_CAPACITY);
    localparam int DIM_W         = 3;
    localparam int BOX_W         = 2 * MAX_DIMS * COORD_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int QUEUE_DEPTH   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_DIM0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_DIM3  = 3'd4;

    typedef struct packed {
        logic               start_set;
        logic [IDX_W-1:0]   row_index;
        logic signed [31:0] low_dim0;
        logic signed [31:0] high_dim0;
        logic signed [31:0] low_dim1;
        logic signed [31:0] high_dim1;
        logic signed [31:0] low_dim2;
        logic signed [31:0] high_dim2;
        logic signed [31:0] low_dim3;
        logic signed [31:0] high_dim3;
    } box_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        logic             keep_flag;
        logic             store_overflow;
    } box_out_t;

    // Box as held in the queue between front and back.
    typedef struct packed {
        logic                             start_set;
        logic [IDX_W-1:0]                 row_index;
        logic [MAX_DIMS-1:0][COORD_W-1:0] lows;
        logic [MAX_DIMS-1:0][COORD_W-1:0] highs;
    } box_work_t;

endpackage

// ===== hw/rtl/rod_ram.sv =====
module rod_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/rod_front.sv =====
module rod_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rod_pkg::box_in_t  box_in,
    output logic              q_valid,
    input  logic              q_take,
    output rod_pkg::box_work_t q_data
);
    import rod_pkg::*;

    box_work_t slot_reg [QUEUE_DEPTH];
    logic [1:0] count_reg, count_next;
    logic       wptr_reg, rptr_reg;
    logic       do_push, do_take;
    box_work_t  packed_box;

    // Repack the input beat into per-dimension arrays.
    always_comb
    begin
        packed_box.start_set = box_in.start_set;
        packed_box.row_index = box_in.row_index;
        packed_box.lows[0]   = box_in.low_dim0;
        packed_box.highs[0]  = box_in.high_dim0;
        packed_box.lows[1]   = box_in.low_dim1;
        packed_box.highs[1]  = box_in.high_dim1;
        packed_box.lows[2]   = box_in.low_dim2;
        packed_box.highs[2]  = box_in.high_dim2;
        packed_box.lows[3]   = box_in.low_dim3;
        packed_box.highs[3]  = box_in.high_dim3;
    end

    assign full    = (count_reg == 2'(QUEUE_DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_take = q_take && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_take && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_take)
            begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= packed_box;
        end
    end

endmodule

// ===== hw/rtl/rod_back.sv =====
module rod_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_take,
    input  rod_pkg::box_work_t      q_data,
    input  logic [2:0]              dims_used,
    input  logic [3:0][31:0]        tolerance,
    output logic                    empty,
    input  logic                    pop,
    output rod_pkg::box_out_t       box_out
);
    import rod_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] kept_count_reg, kept_count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] limit;
    box_work_t        box_reg;
    logic             keep_reg, keep_next;
    logic             out_valid_reg;
    box_out_t         out_reg;
    logic [BOX_W-1:0] rd_data;
    logic [MAX_DIMS-1:0][COORD_W-1:0] k_lo, k_hi;
    logic [MAX_DIMS-1:0] dim_on, dim_far;
    logic             wr_en;
    logic             finish;
    logic [2:0]       nd;

    rod_ram #(.WIDTH(BOX_W), .DEPTH(KEPT_CAPACITY)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (kept_count_reg[ADDR_W-1:0]),
        .wr_data ({box_reg.lows, box_reg.highs}),
        .rd_addr (scan_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign {k_lo, k_hi} = rd_data;

    // Clamp dims_used to one through MAX_DIMS.
    always_comb
    begin
        nd = dims_used;
        if (dims_used == 3'd0)
        begin
            nd = 3'd1;
        end
        else if (dims_used > 3'(MAX_DIMS))
        begin
            nd = 3'(MAX_DIMS);
        end
    end

    // Per-dimension gap test at 34 bits so nothing wraps.
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            dim_on[d]  = (3'(d) < nd);
            dim_far[d] =
                (($signed({{2{box_reg.lows[d][31]}}, box_reg.lows[d]})
                  - $signed({{2{k_hi[d][31]}}, k_hi[d]}))
                 > $signed({{2{tolerance[d][31]}}, tolerance[d]}))
                || (($signed({{2{k_lo[d][31]}}, k_lo[d]})
                  - $signed({{2{box_reg.highs[d][31]}}, box_reg.highs[d]}))
                 > $signed({{2{tolerance[d][31]}}, tolerance[d]}));
        end
    end

    assign limit  = box_reg.start_set ? '0 : kept_count_reg;
    assign finish = !out_valid_reg || pop;

    // Scan sequencer: each stored box is read from the store, then compared.
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        keep_next       = keep_reg;
        kept_count_next = kept_count_reg;
        q_take          = 1'b0;
        wr_en           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take     = 1'b1;
                    scan_next  = '0;
                    keep_next  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (box_reg.start_set)
                begin
                    kept_count_next = '0;
                end
                if (scan_reg < (box_reg.start_set ? CNT_W'(0) : kept_count_reg))
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if ((dim_far & dim_on) == '0)
                begin
                    keep_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    if (keep_reg && kept_count_reg < CNT_W'(KEPT_CAPACITY))
                    begin
                        wr_en           = 1'b1;
                        kept_count_next = kept_count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kept_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kept_count_reg <= kept_count_next;
            if (state_reg == ST_DONE && finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and result register.
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        keep_reg <= keep_next;
        if (q_take)
        begin
            box_reg <= q_data;
        end
        if (state_reg == ST_DONE && finish)
        begin
            out_reg.result_index   <= box_reg.row_index;
            out_reg.keep_flag      <= keep_reg;
            out_reg.store_overflow <= keep_reg && !(limit < CNT_W'(KEPT_CAPACITY));
        end
    end

    assign empty   = !out_valid_reg;
    assign box_out = out_reg;

endmodule

// ===== hw/rtl/rectangle_overlap_dedup.sv =====
// Greedy rectangle suppression with a store of kept boxes.
// Input channel: a box beat is taken when push is high and full is low.
// A two-entry queue holds boxes waiting to be judged.
// Result channel: while empty is low, the result is on box_out.
// It is taken when pop is high and empty is low.
// Each box is compared against every stored box in turn: a read of the
// store RAM, then a compare, for each stored box. The scan stops early
// at the first overlap. The store RAM has a single registered read port,
// so each compare waits for its read.
// With start_set high, the store is emptied before that box is judged.
// A box that is kept is written to the store when its result is loaded, if the store has room.
// When the result register still holds a beat, the next result waits.
// The queue then fills and full rises.
// Reset empties the queue and the store and marks the result register empty.
// Registers take their reset values: dims_used 2, tolerances 0.
// Configuration writes take effect at once and are meant for idle times.
module rectangle_overlap_dedup (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  rod_pkg::box_in_t            box_in,
    output logic                        empty,
    input  logic                        pop,
    output rod_pkg::box_out_t           box_out,
    input  logic                        cfg_we,
    input  logic [rod_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rod_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rod_pkg::*;

    logic [2:0]       dims_used_reg;
    logic [3:0][31:0] tol_reg;
    logic             q_valid, q_take;
    box_work_t        q_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_used_reg <= 3'd2;
            tol_reg       <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DIMS_USED)
            begin
                dims_used_reg <= cfg_data[2:0];
            end
            else if (cfg_index >= REG_TOL_DIM0 && cfg_index <= REG_TOL_DIM3)
            begin
                tol_reg[2'(cfg_index - REG_TOL_DIM0)] <= cfg_data;
            end
        end
    end

    rod_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .box_in  (box_in),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_data  (q_data)
    );

    rod_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_data    (q_data),
        .dims_used (dims_used_reg),
        .tolerance (tol_reg),
        .empty     (empty),
        .pop       (pop),
        .box_out   (box_out)
    );

endmodule
